// ===== sv/ccrd_pkg.sv =====
// ccrd_pkg: shared types, byte codes and the CRC-16 byte step for the record deframer.
// No dependencies; imported by ccrd_skid, crc_checked_record_deframer and ccrd_checker.
`default_nettype none

package ccrd_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'h02;
  localparam logic [7:0] TYPE_OBS  = 8'h00;
  localparam logic [7:0] TYPE_EPH  = 8'h01;

  // Reflected CRC-16 polynomial
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Status codes
  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_OVER_MAX = 2'd2;

  // One result item
  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       record_kind;
    logic [5:0] sat_index;
    logic [9:0] byte_offset;
    logic       record_done;
    logic       record_ok;
    logic [6:0] sat_count;
    logic [1:0] status;
  } ccrd_result_t;

  // One byte of the reflected CRC: the low byte is mixed, then eight shifts
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[15:8], crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ccrd_skid.sv =====
// ccrd_skid: output register plus one skid entry for result items.
// Depends on ccrd_pkg (ccrd_result_t).
`default_nettype none

module ccrd_skid
  import ccrd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire ccrd_result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ccrd_result_t      out_data
);

  logic         skid_valid;
  ccrd_result_t skid_data;
  logic         take;

  assign take = out_valid && !out_stall;
  // Upstream holds off only while the skid entry is occupied
  assign full = skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) out_data <= skid_data;
      else            out_data <= push_data;
    end else if (!out_valid) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crc_checked_record_deframer.sv =====
// crc_checked_record_deframer: byte-stream deframer for CRC-16 checked records.
// Depends on ccrd_pkg and ccrd_skid.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_stall, in_byte      | in, stall out
//   output   | out_valid, out_stall, 9 fields   | out, stall in
//
// One byte per cycle while in_stall is low: each transfer updates the framing state
// and CRC in combinational logic and yields one registered result.
// The result register plus a skid entry let input keep flowing for one
// extra transfer while output stalls; in_stall then rises until the skid
// entry empties.
// Synchronous active-high reset returns the framer to sync hunting.
`default_nettype none

module crc_checked_record_deframer
  import ccrd_pkg::*;
#(
  parameter int OBS_BYTES    = 128,
  parameter int EPH_BYTES    = 128,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_SATS     = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            body_valid,
  output logic [7:0]      body_byte,
  output logic            record_kind,
  output logic [5:0]      sat_index,
  output logic [9:0]      byte_offset,
  output logic            record_done,
  output logic            record_ok,
  output logic [6:0]      sat_count,
  output logic [1:0]      status
);

  // Phase codes
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_HEAD  = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;

  localparam int FC_MAX = (MAX_SATS > HEADER_BYTES) ? MAX_SATS : HEADER_BYTES;
  localparam int FC_W   = $clog2(FC_MAX + 1);

  logic [2:0]      phase, phase_next;
  logic [FC_W-1:0] field_counter, field_counter_next;
  logic [15:0]     crc_reg, crc_reg_next;
  logic [31:0]     received_check, received_check_next;
  logic [31:0]     count_reg, count_reg_next;
  logic            kind_reg, kind_reg_next;
  logic [5:0]      block_index, block_index_next;
  logic [9:0]      block_offset, block_offset_next;

  logic            accept;
  logic            full;
  ccrd_result_t    res, out_data;
  logic [FC_W-1:0] fc_inc;
  logic [10:0]     off_inc;
  logic [10:0]     blk_len;
  logic [15:0]     crc_step;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full;
  assign fc_inc   = field_counter + 1'b1;
  assign off_inc  = {1'b0, block_offset} + 11'd1;
  assign blk_len  = kind_reg ? 11'(EPH_BYTES) : 11'(OBS_BYTES);
  assign crc_step = crc_byte(crc_reg, in_byte);

  // Next state and result for the byte at the input
  always_comb begin
    phase_next          = phase;
    field_counter_next  = field_counter;
    crc_reg_next        = crc_reg;
    received_check_next = received_check;
    count_reg_next      = count_reg;
    kind_reg_next       = kind_reg;
    block_index_next    = block_index;
    block_offset_next   = block_offset;
    res                 = '0;

    case (phase)
      PH_HUNT: begin
        if (in_byte == SYNC_BYTE) begin
          crc_reg_next = crc_byte(16'h0000, in_byte);
          phase_next   = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (in_byte == TYPE_OBS || in_byte == TYPE_EPH) begin
          kind_reg_next      = in_byte[0];
          crc_reg_next       = crc_step;
          field_counter_next = '0;
          phase_next         = PH_SIZE;
        end else begin
          res.status = ST_BAD_TYPE;
          // A stray sync byte in the type slot restarts the frame
          if (in_byte == SYNC_BYTE) begin
            crc_reg_next = crc_byte(16'h0000, in_byte);
            phase_next   = PH_TYPE;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_SIZE: begin
        crc_reg_next       = crc_step;
        field_counter_next = fc_inc;
        if (32'(fc_inc) >= 32'd4) begin
          count_reg_next     = '0;
          field_counter_next = '0;
          if (kind_reg) begin
            phase_next        = PH_BODY;
            block_index_next  = '0;
            block_offset_next = '0;
          end else begin
            phase_next = PH_HEAD;
          end
        end
      end
      PH_HEAD: begin
        crc_reg_next = crc_step;
        // Satellite count: little-endian word at header offsets 8..11
        if (32'(field_counter) >= 32'd8 && 32'(field_counter) < 32'd12) begin
          count_reg_next[8*field_counter[1:0] +: 8] = in_byte;
        end
        field_counter_next = fc_inc;
        if (32'(fc_inc) >= 32'(HEADER_BYTES)) begin
          if (count_reg_next > 32'(MAX_SATS)) begin
            res.status = ST_OVER_MAX;
            phase_next = PH_HUNT;
          end else if (count_reg_next == 32'd0) begin
            field_counter_next  = '0;
            received_check_next = '0;
            phase_next          = PH_CHECK;
          end else begin
            field_counter_next = '0;
            block_index_next   = '0;
            block_offset_next  = '0;
            phase_next         = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_reg_next    = crc_step;
        res.body_valid  = 1'b1;
        res.body_byte   = in_byte;
        res.record_kind = kind_reg;
        res.sat_index   = kind_reg ? 6'd0 : block_index;
        res.byte_offset = block_offset;
        if (off_inc >= blk_len) begin
          // End of a satellite block or of the ephemeris body
          block_offset_next  = '0;
          field_counter_next = fc_inc;
          block_index_next   = 6'(fc_inc);
          if (kind_reg || 32'(fc_inc) >= count_reg) begin
            field_counter_next  = '0;
            received_check_next = '0;
            phase_next          = PH_CHECK;
          end
        end else begin
          block_offset_next = off_inc[9:0];
        end
      end
      PH_CHECK: begin
        received_check_next[8*field_counter[1:0] +: 8] = in_byte;
        field_counter_next = fc_inc;
        if (32'(fc_inc) >= 32'd4) phase_next = PH_TRAIL;
      end
      PH_TRAIL: begin
        res.record_done = 1'b1;
        res.record_kind = kind_reg;
        res.record_ok   = (received_check == {16'h0000, crc_reg});
        if (!kind_reg) begin
          res.sat_count = (count_reg > 32'd127) ? 7'd127 : count_reg[6:0];
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // State registers advance once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      field_counter  <= '0;
      crc_reg        <= '0;
      received_check <= '0;
      count_reg      <= '0;
      kind_reg       <= 1'b0;
      block_index    <= '0;
      block_offset   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      field_counter  <= field_counter_next;
      crc_reg        <= crc_reg_next;
      received_check <= received_check_next;
      count_reg      <= count_reg_next;
      kind_reg       <= kind_reg_next;
      block_index    <= block_index_next;
      block_offset   <= block_offset_next;
    end
  end

  // Result register and skid entry
  ccrd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign body_valid  = out_data.body_valid;
  assign body_byte   = out_data.body_byte;
  assign record_kind = out_data.record_kind;
  assign sat_index   = out_data.sat_index;
  assign byte_offset = out_data.byte_offset;
  assign record_done = out_data.record_done;
  assign record_ok   = out_data.record_ok;
  assign sat_count   = out_data.sat_count;
  assign status      = out_data.status;

endmodule

`default_nettype wire

// ===== sv/ccrd_checker.sv =====
// ccrd_checker: port-level assertions for crc_checked_record_deframer, with its bind.
// Depends on ccrd_pkg (status codes).
`default_nettype none

module ccrd_checker
  import ccrd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       body_valid,
  input wire logic       record_kind,
  input wire logic       record_done,
  input wire logic       record_ok,
  input wire logic [6:0] sat_count,
  input wire logic [1:0] status
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A byte is either body or trailer, never both
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && body_valid |-> !record_done && !record_ok && status == ST_NORMAL)
    else $error("body transfer carries trailer or status flags");

  // Verdict and count only come with the trailer
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_ok || sat_count != 7'd0) |-> record_done)
    else $error("verdict without trailer");

  // Ephemeris records report no satellite count
  a_eph_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done && record_kind |-> sat_count == 7'd0)
    else $error("ephemeris trailer with satellite count");

endmodule

bind crc_checked_record_deframer ccrd_checker u_ccrd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .body_valid  (body_valid),
  .record_kind (record_kind),
  .record_done (record_done),
  .record_ok   (record_ok),
  .sat_count   (sat_count),
  .status      (status)
);

`default_nettype wire
